[hw/rtl/cartridge_bank_mapper_latch_assert.svh]
// Assertion macros for the checker of the bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_LATCH_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_LATCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CBML_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bank mapper check failed");

// Next-cycle implication, disabled while reset is high.
`define CBML_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bank mapper check failed");

`endif

[hw/rtl/cbml_pkg.sv]
// Types and constants shared by the bank mapper modules.
`default_nettype none

package cbml_pkg;

  localparam int BANK_BITS     = 10;
  localparam int NUM_BANK_REGS = 6;
  localparam int REG_IDX_BITS  = 3;
  localparam int CFG_IDX_BITS  = 2;

  // Item kinds.
  localparam logic OP_CPU_WRITE = 1'b0;
  localparam logic OP_GFX_ADDR  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRG_AND = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRG_OR  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHR_AND = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHR_OR  = 2'd3;

  localparam logic [BANK_BITS-1:0] PRG_AND_RESET = 10'd15;
  localparam logic [BANK_BITS-1:0] PRG_OR_RESET  = 10'd0;
  localparam logic [BANK_BITS-1:0] CHR_AND_RESET = 10'd31;
  localparam logic [BANK_BITS-1:0] CHR_OR_RESET  = 10'd0;

  // CPU write decode and tile-fetch snoop constants.
  localparam logic [3:0]  WRITE_BASE = 4'hA;
  localparam logic [15:0] SNOOP_MASK = 16'h2FF0;
  localparam logic [15:0] SNOOP_FD   = 16'h0FD0;
  localparam logic [15:0] SNOOP_FE   = 16'h0FE0;

  // Fixed program banks of the upper three windows.
  localparam logic [7:0] PRG_FIXED_D = 8'h0D;
  localparam logic [7:0] PRG_FIXED_E = 8'h0E;
  localparam logic [7:0] PRG_FIXED_F = 8'h0F;

  // Bank register that holds the mirroring bit.
  localparam int MIRROR_REG = 5;

  typedef struct packed {
    logic        opcode;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [BANK_BITS-1:0] prg_bank_slot0;
    logic [BANK_BITS-1:0] prg_bank_slot1;
    logic [BANK_BITS-1:0] prg_bank_slot2;
    logic [BANK_BITS-1:0] prg_bank_slot3;
    logic [BANK_BITS-1:0] chr_bank_low;
    logic [BANK_BITS-1:0] chr_bank_high;
    logic                 mirror_horizontal;
  } rsp_t;

  typedef struct packed {
    logic [BANK_BITS-1:0] prg_and;
    logic [BANK_BITS-1:0] prg_or;
    logic [BANK_BITS-1:0] chr_and;
    logic [BANK_BITS-1:0] chr_or;
  } cfg_t;

  typedef struct packed {
    logic [NUM_BANK_REGS-1:0][7:0] banks;
    logic [1:0]                    latches;
  } map_state_t;

  localparam map_state_t STATE_RESET = '{
    banks:   {8'd0, 8'd0, 8'd0, 8'd2, 8'd0, 8'd0},
    latches: 2'b00
  };

endpackage

`default_nettype wire

[hw/rtl/cbml_map.sv]
// Next-state and mapping logic for one item of the bank mapper.
`default_nettype none

module cbml_map (
  input  cbml_pkg::req_t       item,
  input  cbml_pkg::map_state_t state,
  input  cbml_pkg::cfg_t       cfg,
  output cbml_pkg::map_state_t state_next,
  output cbml_pkg::rsp_t       result
);

  logic [3:0]                        window;
  logic [cbml_pkg::REG_IDX_BITS-1:0] reg_sel;
  logic                              write_hit;
  logic [15:0]                       snoop;
  logic                              snoop_hit;
  logic [7:0]                        chr_low_raw;
  logic [7:0]                        chr_high_raw;

  function automatic logic [cbml_pkg::BANK_BITS-1:0] widen(input logic [7:0] v);
    widen = {{(cbml_pkg::BANK_BITS-8){1'b0}}, v};
  endfunction

  assign window    = item.address[15:12];
  // Windows 0xA to 0xF map to registers 0 to 5; the low three bits are enough.
  assign reg_sel   = window[cbml_pkg::REG_IDX_BITS-1:0] -
                     cbml_pkg::WRITE_BASE[cbml_pkg::REG_IDX_BITS-1:0];
  assign write_hit = (item.opcode == cbml_pkg::OP_CPU_WRITE) &&
                     (window >= cbml_pkg::WRITE_BASE);
  assign snoop     = item.address & cbml_pkg::SNOOP_MASK;
  assign snoop_hit = (item.opcode == cbml_pkg::OP_GFX_ADDR) &&
                     ((snoop == cbml_pkg::SNOOP_FD) || (snoop == cbml_pkg::SNOOP_FE));

  always_comb begin
    state_next = state;
    for (int i = 0; i < cbml_pkg::NUM_BANK_REGS; i++) begin
      if (write_hit && (reg_sel == i[cbml_pkg::REG_IDX_BITS-1:0])) begin
        state_next.banks[i] = item.data;
      end
    end
    // Bit 12 picks which half's latch the fetch sets.
    if (snoop_hit) begin
      state_next.latches[item.address[12]] = item.address[5];
    end
  end

  assign chr_low_raw  = state_next.latches[0] ? state_next.banks[2] : state_next.banks[1];
  assign chr_high_raw = state_next.latches[1] ? state_next.banks[4] : state_next.banks[3];

  always_comb begin
    result.prg_bank_slot0 = (widen(state_next.banks[0]) & cfg.prg_and) | cfg.prg_or;
    result.prg_bank_slot1 = (widen(cbml_pkg::PRG_FIXED_D) & cfg.prg_and) | cfg.prg_or;
    result.prg_bank_slot2 = (widen(cbml_pkg::PRG_FIXED_E) & cfg.prg_and) | cfg.prg_or;
    result.prg_bank_slot3 = (widen(cbml_pkg::PRG_FIXED_F) & cfg.prg_and) | cfg.prg_or;
    result.chr_bank_low   = (widen(chr_low_raw) & cfg.chr_and) | cfg.chr_or;
    result.chr_bank_high  = (widen(chr_high_raw) & cfg.chr_and) | cfg.chr_or;
    result.mirror_horizontal = state_next.banks[cbml_pkg::MIRROR_REG][0];
  end

endmodule

`default_nettype wire

[hw/rtl/cartridge_bank_mapper_latch.sv]
// Top level of the cartridge bank mapper with tile-fetch latches.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------
//   req     | in        | req_valid/req_stall | req_item (cbml_pkg::req_t)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_item (cbml_pkg::rsp_t)
//   cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled.
// The item sits in an input register, then the mapping logic updates the bank
// registers and latches and loads the result register in the same cycle.
// Synchronous reset restores bank registers, latches and masks; no clearing pass.
// A stalled result holds the input register, and req_stall rises only then.
`default_nettype none

module cartridge_bank_mapper_latch (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  cbml_pkg::req_t                      req_item,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output cbml_pkg::rsp_t                      rsp_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbml_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [cbml_pkg::BANK_BITS-1:0]      cfg_data
);

  logic                 hold_valid;
  cbml_pkg::req_t       hold_item;
  cbml_pkg::map_state_t state;
  cbml_pkg::map_state_t state_next;
  cbml_pkg::cfg_t       cfg;
  cbml_pkg::rsp_t       result;
  logic                 rsp_open;
  logic                 advance;

  assign cfg_ready = 1'b1;
  assign rsp_open  = !rsp_valid || !rsp_stall;
  assign advance   = hold_valid && rsp_open;
  assign req_stall = hold_valid && !rsp_open;

  cbml_map u_map (
    .item       (hold_item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prg_and <= cbml_pkg::PRG_AND_RESET;
      cfg.prg_or  <= cbml_pkg::PRG_OR_RESET;
      cfg.chr_and <= cbml_pkg::CHR_AND_RESET;
      cfg.chr_or  <= cbml_pkg::CHR_OR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cbml_pkg::CFG_PRG_AND: cfg.prg_and <= cfg_data;
        cbml_pkg::CFG_PRG_OR:  cfg.prg_or  <= cfg_data;
        cbml_pkg::CFG_CHR_AND: cfg.chr_and <= cfg_data;
        cbml_pkg::CFG_CHR_OR:  cfg.chr_or  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      hold_item <= req_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      state     <= cbml_pkg::STATE_RESET;
    end else if (advance) begin
      rsp_valid <= 1'b1;
      state     <= state_next;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_item <= result;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cbml_checker.sv]
// Port-level checker for the bank mapper, bound to its top level.
`default_nettype none

`include "cartridge_bank_mapper_latch_assert.svh"

module cbml_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  input  wire logic                              req_stall,
  input  wire logic                              rsp_valid,
  input  wire logic                              rsp_stall,
  input  wire cbml_pkg::rsp_t                    rsp_item,
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_ready
);

  logic req_take;
  logic cfg_take;

  assign req_take = req_valid && !req_stall;
  assign cfg_take = cfg_valid && cfg_ready;

  // A waiting result keeps its value.
  `CBML_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

  // Nothing is shown in the first cycle after reset.
  `CBML_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !rsp_valid)

  // The input side is held back only by a stalled result.
  `CBML_ASSERT_NOW(a_stall_cause, clk, rst, req_stall, rsp_valid && rsp_stall)

  // A fresh result follows an item taken into the input register.
  `CBML_ASSERT_NOW(a_rsp_origin, clk, rst, $rose(rsp_valid), $past(req_take, 2))

  // Configuration writes are never refused.
  `CBML_ASSERT_NOW(a_cfg_open, clk, rst, cfg_valid, cfg_take)

endmodule

bind cartridge_bank_mapper_latch cbml_checker u_cbml_checker (.*);

`default_nettype wire
